/* rtl/core/zed_pkg.sv */
// Shared types, constants and tables for the ZYZ Euler decomposition block.
// No dependencies; every other file in rtl/core refers to it by scoped name.
`default_nettype none
package zed_pkg;

  localparam int CORDIC_STAGES_DEF = 18;
  localparam int FRAC_BITS_DEF     = 16;

  localparam int IN_W     = 18;   // Q1.16 element parts
  localparam int PROD_W   = 36;   // one 18x18 product
  localparam int RAW_W    = 38;   // determinant parts and raw lanes
  localparam int MAG_W    = 40;   // absolute values, padded to whole bytes
  localparam int NGRP     = MAG_W / 8;
  localparam int SHW      = 6;    // normalising shift amount
  localparam int NORM_POS = 40;   // top bit position after normalisation
  localparam int VW       = 46;   // CORDIC x/y datapath
  localparam int ZW       = 34;   // CORDIC angle accumulator, Q.30 radians
  localparam int RW       = 36;   // combined angles before rounding
  localparam int ANG_FRAC = 30;
  localparam int TOL_W    = 16;
  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);

  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint TWO_PI_Q30  = 64'd6746518852;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic        [MAG_W-1:0] mag_t;
  typedef logic signed [VW-1:0]    vw_t;
  typedef logic signed [ZW-1:0]    ang_t;
  typedef logic signed [ZW:0]      angx_t;
  typedef logic signed [RW-1:0]    rw_t;

  typedef struct packed {
    vw_t re;
    vw_t im;
  } vec_t;

  // One normalised matrix on its way from the front end to the angle engine.
  typedef struct packed {
    vec_t det;
    vec_t d;       // u11
    vec_t c;       // u10
    vec_t a;       // u00
    vec_t b;       // u01
    logic d_zero;
    logic c_zero;
  } job_t;

  // atan(2^-i) in Q.30, truncated.
  function automatic ang_t atan_q30(input int i);
    ang_t r;
    unique case (i)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd7;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Bring an angle difference back into (-pi, pi].
  function automatic ang_t wrap_pi(input angx_t v);
    angx_t r;
    r = v;
    if (r > angx_t'(PI_Q30)) begin
      r = r - angx_t'(TWO_PI_Q30);
    end else if (r <= -angx_t'(PI_Q30)) begin
      r = r + angx_t'(TWO_PI_Q30);
    end
    return r[ZW-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/zyz_euler_decompose.sv */
// Top level of the ZYZ Euler decomposition block: front end, job queue, angle engine.
// Depends on zed_pkg, zed_front, zed_queue, zed_back.
`default_nettype none
// Takes one 2x2 complex unitary per transfer (Q1.16 parts) and returns its ZYZ
// Euler angles alpha, beta, gamma and the global phase (argument of the
// determinant): alpha and gamma in signed Q3.FRAC_BITS, beta in unsigned
// Q2.FRAC_BITS and the phase in signed Q2.FRAC_BITS radians, rounded to nearest,
// plus four flags that are set when an angle's magnitude exceeds angle_tolerance.
// The block is fully pipelined and accepts one matrix every cycle while the output
// is not stalled. The front end registers capture, products, determinant, three
// normalisation steps and shift; jobs then pass through the job queue and the
// angle engine, whose depth is set by the two CORDIC pipelines in series
// (element angles and magnitudes, then beta). A stall on the output holds the
// angle engine; the front end keeps running until the four-entry queue fills,
// after which in_stall is raised. angle_tolerance is written through the cfg
// channel, which is always ready; write it only while no matrices are in flight.
module zyz_euler_decompose #(
  parameter int CORDIC_STAGES = zed_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = zed_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [zed_pkg::TOL_W-1:0]        cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [zed_pkg::IN_W-1:0]  u00_re,
  input  wire logic signed [zed_pkg::IN_W-1:0]  u00_im,
  input  wire logic signed [zed_pkg::IN_W-1:0]  u01_re,
  input  wire logic signed [zed_pkg::IN_W-1:0]  u01_im,
  input  wire logic signed [zed_pkg::IN_W-1:0]  u10_re,
  input  wire logic signed [zed_pkg::IN_W-1:0]  u10_im,
  input  wire logic signed [zed_pkg::IN_W-1:0]  u11_re,
  input  wire logic signed [zed_pkg::IN_W-1:0]  u11_im,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [FRAC_BITS+3:0]           alpha_angle,
  output logic        [FRAC_BITS+1:0]           beta_angle,
  output logic signed [FRAC_BITS+3:0]           gamma_angle,
  output logic signed [FRAC_BITS+2:0]           global_phase,
  output logic                                  gamma_needed,
  output logic                                  beta_needed,
  output logic                                  alpha_needed,
  output logic                                  phase_needed
);

  logic [zed_pkg::TOL_W-1:0] angle_tolerance;

  logic          job_valid, job_full, job_pop, job_empty;
  zed_pkg::job_t job_in, job_head;

  // Configuration: one register, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_tolerance <= zed_pkg::TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      angle_tolerance <= cfg_data;
    end
  end

  // Front end: determinant and normalisation of every vector.
  zed_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .u00_re(u00_re), .u00_im(u00_im), .u01_re(u01_re), .u01_im(u01_im),
    .u10_re(u10_re), .u10_im(u10_im), .u11_re(u11_re), .u11_im(u11_im),
    .job_valid(job_valid), .job(job_in), .job_full(job_full)
  );

  // Decouple the two halves so each can hold on its own.
  zed_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(job_valid), .push_data(job_in), .full(job_full),
    .pop(job_pop), .empty(job_empty), .head(job_head)
  );

  // Angle engine with the output register.
  zed_back #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst),
    .job_empty(job_empty), .job(job_head), .job_pop(job_pop),
    .tol(angle_tolerance),
    .out_valid(out_valid), .out_stall(out_stall),
    .alpha_angle(alpha_angle), .beta_angle(beta_angle),
    .gamma_angle(gamma_angle), .global_phase(global_phase),
    .gamma_needed(gamma_needed), .beta_needed(beta_needed),
    .alpha_needed(alpha_needed), .phase_needed(phase_needed)
  );

endmodule
`default_nettype wire

/* rtl/core/zed_front.sv */
// Front end: input capture, determinant, and per-vector normalisation.
// Depends on zed_pkg.
`default_nettype none
module zed_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [zed_pkg::IN_W-1:0]    u00_re,
  input  wire logic signed [zed_pkg::IN_W-1:0]    u00_im,
  input  wire logic signed [zed_pkg::IN_W-1:0]    u01_re,
  input  wire logic signed [zed_pkg::IN_W-1:0]    u01_im,
  input  wire logic signed [zed_pkg::IN_W-1:0]    u10_re,
  input  wire logic signed [zed_pkg::IN_W-1:0]    u10_im,
  input  wire logic signed [zed_pkg::IN_W-1:0]    u11_re,
  input  wire logic signed [zed_pkg::IN_W-1:0]    u11_im,
  output logic                                    job_valid,
  output zed_pkg::job_t                           job,
  input  wire logic                               job_full
);

  localparam int NL = 5;  // det, d, c, a, b

  function automatic zed_pkg::mag_t abs_raw(input zed_pkg::raw_t v);
    zed_pkg::raw_t n;
    n = -v;
    return v[zed_pkg::RAW_W-1] ? zed_pkg::mag_t'(n) : zed_pkg::mag_t'(v);
  endfunction

  function automatic logic [2:0] top_in_byte(input logic [7:0] b);
    logic [2:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = 3'(i);
    end
    return p;
  endfunction

  function automatic logic [zed_pkg::SHW-1:0] shift_of(
    input logic [zed_pkg::NGRP-1:0]      nz,
    input logic [zed_pkg::NGRP-1:0][2:0] pos
  );
    logic [zed_pkg::SHW-1:0] tb;
    logic                    hit;
    tb  = '0;
    hit = 1'b0;
    for (int g = 0; g < zed_pkg::NGRP; g++) begin
      if (nz[g]) begin
        tb  = zed_pkg::SHW'(g * 8) + {3'b000, pos[g]};
        hit = 1'b1;
      end
    end
    return hit ? zed_pkg::SHW'(zed_pkg::NORM_POS) - tb : '0;
  endfunction

  logic [6:0] vld;
  logic       adv;

  // S0: captured matrix
  logic signed [zed_pkg::IN_W-1:0] ar0, ai0, br0, bi0, cr0, ci0, dr0, di0;
  // S1: products and raw elements
  logic signed [zed_pkg::PROD_W-1:0] pr [8];
  logic signed [zed_pkg::IN_W-1:0] ar1, ai1, br1, bi1, cr1, ci1, dr1, di1;
  // S2..S5: lanes
  zed_pkg::raw_t re2 [NL], im2 [NL], re3 [NL], im3 [NL];
  zed_pkg::raw_t re4 [NL], im4 [NL], re5 [NL], im5 [NL];
  zed_pkg::mag_t mx3 [4];
  logic [zed_pkg::NGRP-1:0]      gnz4 [4];
  logic [zed_pkg::NGRP-1:0][2:0] gpos4 [4];
  logic [zed_pkg::SHW-1:0] sh5 [4];
  logic dz5, cz5;

  assign adv       = !(vld[6] && job_full);
  assign in_stall  = !adv;
  assign job_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ar0 <= u00_re; ai0 <= u00_im; br0 <= u01_re; bi0 <= u01_im;
      cr0 <= u10_re; ci0 <= u10_im; dr0 <= u11_re; di0 <= u11_im;

      pr[0] <= ar0 * dr0; pr[1] <= ai0 * di0; pr[2] <= br0 * cr0; pr[3] <= bi0 * ci0;
      pr[4] <= ar0 * di0; pr[5] <= ai0 * dr0; pr[6] <= br0 * ci0; pr[7] <= bi0 * cr0;
      ar1 <= ar0; ai1 <= ai0; br1 <= br0; bi1 <= bi0;
      cr1 <= cr0; ci1 <= ci0; dr1 <= dr0; di1 <= di0;

      re2[0] <= zed_pkg::raw_t'(pr[0]) - zed_pkg::raw_t'(pr[1])
              - zed_pkg::raw_t'(pr[2]) + zed_pkg::raw_t'(pr[3]);
      im2[0] <= zed_pkg::raw_t'(pr[4]) + zed_pkg::raw_t'(pr[5])
              - zed_pkg::raw_t'(pr[6]) - zed_pkg::raw_t'(pr[7]);
      re2[1] <= zed_pkg::raw_t'(dr1); im2[1] <= zed_pkg::raw_t'(di1);
      re2[2] <= zed_pkg::raw_t'(cr1); im2[2] <= zed_pkg::raw_t'(ci1);
      re2[3] <= zed_pkg::raw_t'(ar1); im2[3] <= zed_pkg::raw_t'(ai1);
      re2[4] <= zed_pkg::raw_t'(br1); im2[4] <= zed_pkg::raw_t'(bi1);

      // Largest component per vector; the first row shares one scale.
      for (int k = 0; k < 3; k++) begin
        mx3[k] <= (abs_raw(re2[k]) > abs_raw(im2[k])) ? abs_raw(re2[k]) : abs_raw(im2[k]);
      end
      begin
        zed_pkg::mag_t m;
        m = abs_raw(re2[3]);
        if (abs_raw(im2[3]) > m) m = abs_raw(im2[3]);
        if (abs_raw(re2[4]) > m) m = abs_raw(re2[4]);
        if (abs_raw(im2[4]) > m) m = abs_raw(im2[4]);
        mx3[3] <= m;
      end

      for (int k = 0; k < 4; k++) begin
        for (int g = 0; g < zed_pkg::NGRP; g++) begin
          gnz4[k][g]  <= |mx3[k][g*8 +: 8];
          gpos4[k][g] <= top_in_byte(mx3[k][g*8 +: 8]);
        end
        sh5[k] <= shift_of(gnz4[k], gpos4[k]);
      end
      dz5 <= !(|gnz4[1]);
      cz5 <= !(|gnz4[2]);

      for (int k = 0; k < NL; k++) begin
        re3[k] <= re2[k]; im3[k] <= im2[k];
        re4[k] <= re3[k]; im4[k] <= im3[k];
        re5[k] <= re4[k]; im5[k] <= im4[k];
      end

      job.det.re <= zed_pkg::vw_t'(re5[0]) <<< sh5[0];
      job.det.im <= zed_pkg::vw_t'(im5[0]) <<< sh5[0];
      job.d.re   <= zed_pkg::vw_t'(re5[1]) <<< sh5[1];
      job.d.im   <= zed_pkg::vw_t'(im5[1]) <<< sh5[1];
      job.c.re   <= zed_pkg::vw_t'(re5[2]) <<< sh5[2];
      job.c.im   <= zed_pkg::vw_t'(im5[2]) <<< sh5[2];
      job.a.re   <= zed_pkg::vw_t'(re5[3]) <<< sh5[3];
      job.a.im   <= zed_pkg::vw_t'(im5[3]) <<< sh5[3];
      job.b.re   <= zed_pkg::vw_t'(re5[4]) <<< sh5[3];
      job.b.im   <= zed_pkg::vw_t'(im5[4]) <<< sh5[3];
      job.d_zero <= dz5;
      job.c_zero <= cz5;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/zed_queue.sv */
// Short job queue between the front end and the angle engine.
// Depends on zed_pkg.
`default_nettype none
module zed_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire zed_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output zed_pkg::job_t      head
);

  zed_pkg::job_t                mem [zed_pkg::QDEPTH];
  logic [zed_pkg::QAW-1:0]      wp, rp;
  logic [zed_pkg::QAW:0]        cnt;
  logic                         do_push, do_pop;

  assign full    = (cnt == (zed_pkg::QAW+1)'(zed_pkg::QDEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == zed_pkg::QAW'(zed_pkg::QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == zed_pkg::QAW'(zed_pkg::QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/zed_cordic.sv */
// Pipelined vectoring CORDIC: angle (Q.30) and gain-scaled magnitude of (x, y).
// Depends on zed_pkg. Registers a pre-rotation, the iteration stages and a clamp in turn, each only while en is high.
`default_nettype none
module zed_cordic #(
  parameter int STAGES = zed_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire zed_pkg::vw_t x_in,
  input  wire zed_pkg::vw_t y_in,
  output zed_pkg::ang_t     ang,
  output zed_pkg::vw_t      mag
);

  zed_pkg::vw_t  xs [STAGES+1];
  zed_pkg::vw_t  ys [STAGES+1];
  zed_pkg::ang_t zs [STAGES+1];
  logic          zf [STAGES+1];

  // Pre-rotate the left half-plane by a quarter turn.
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[zed_pkg::VW-1]) begin
        if (!y_in[zed_pkg::VW-1]) begin
          xs[0] <= y_in;
          ys[0] <= -x_in;
          zs[0] <= zed_pkg::ang_t'(zed_pkg::HALF_PI_Q30);
        end else begin
          xs[0] <= -y_in;
          ys[0] <= x_in;
          zs[0] <= -zed_pkg::ang_t'(zed_pkg::HALF_PI_Q30);
        end
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (!ys[i][zed_pkg::VW-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + zed_pkg::atan_q30(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - zed_pkg::atan_q30(i);
        end
      end
    end
  end

  // Clamp to [-pi, pi]; a zero vector reads as angle and magnitude zero.
  always_ff @(posedge clk) begin
    if (en) begin
      if (zf[STAGES]) begin
        ang <= '0;
        mag <= '0;
      end else begin
        mag <= xs[STAGES];
        if (zs[STAGES] > zed_pkg::ang_t'(zed_pkg::PI_Q30)) begin
          ang <= zed_pkg::ang_t'(zed_pkg::PI_Q30);
        end else if (zs[STAGES] < -zed_pkg::ang_t'(zed_pkg::PI_Q30)) begin
          ang <= -zed_pkg::ang_t'(zed_pkg::PI_Q30);
        end else begin
          ang <= zs[STAGES];
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/zed_back.sv */
// Angle engine: five CORDICs on the normalised vectors, a sixth for beta,
// then phase removal, combination, rounding and flags. Depends on zed_pkg, zed_cordic.
`default_nettype none
module zed_back #(
  parameter int CORDIC_STAGES = zed_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = zed_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        job_empty,
  input  wire zed_pkg::job_t               job,
  output logic                             job_pop,
  input  wire logic [zed_pkg::TOL_W-1:0]   tol,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [FRAC_BITS+3:0]      alpha_angle,
  output logic        [FRAC_BITS+1:0]      beta_angle,
  output logic signed [FRAC_BITS+3:0]      gamma_angle,
  output logic signed [FRAC_BITS+2:0]      global_phase,
  output logic                             gamma_needed,
  output logic                             beta_needed,
  output logic                             alpha_needed,
  output logic                             phase_needed
);

  localparam int     LC        = CORDIC_STAGES + 2;
  localparam int     LB        = 2 * LC + 3;
  localparam int     SH        = zed_pkg::ANG_FRAC - FRAC_BITS;
  localparam longint RND_HALF  = (64'sd1 << SH) >>> 1;

  function automatic logic [zed_pkg::RW-1:0] abs_rw(input zed_pkg::rw_t v);
    zed_pkg::rw_t n;
    n = -v;
    return v[zed_pkg::RW-1] ? n : v;
  endfunction

  logic          adv;
  logic [LB-1:0] vld;

  zed_pkg::ang_t g_a, d_a, c_a, beta_a;
  zed_pkg::vw_t  m00, m01;
  zed_pkg::ang_t p_half, sum_c, diff_c;

  logic          dz_d [LC];
  logic          cz_d [LC];
  zed_pkg::ang_t sum_d [LC], diff_d [LC], g_d [LC];

  zed_pkg::rw_t alpha_r, gamma_r, beta_r, phase_r;
  zed_pkg::rw_t alpha_q, gamma_q, beta_q, phase_q;

  assign adv       = !(out_valid && out_stall);
  assign job_pop   = adv && !job_empty;
  assign out_valid = vld[LB-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LB-2:0], !job_empty};
    end
  end

  zed_cordic #(.STAGES(CORDIC_STAGES)) u_det (
    .clk(clk), .en(adv), .x_in(job.det.re), .y_in(job.det.im), .ang(g_a), .mag()
  );
  zed_cordic #(.STAGES(CORDIC_STAGES)) u_d (
    .clk(clk), .en(adv), .x_in(job.d.re), .y_in(job.d.im), .ang(d_a), .mag()
  );
  zed_cordic #(.STAGES(CORDIC_STAGES)) u_c (
    .clk(clk), .en(adv), .x_in(job.c.re), .y_in(job.c.im), .ang(c_a), .mag()
  );
  zed_cordic #(.STAGES(CORDIC_STAGES)) u_a (
    .clk(clk), .en(adv), .x_in(job.a.re), .y_in(job.a.im), .ang(), .mag(m00)
  );
  zed_cordic #(.STAGES(CORDIC_STAGES)) u_b (
    .clk(clk), .en(adv), .x_in(job.b.re), .y_in(job.b.im), .ang(), .mag(m01)
  );

  // Remove half the determinant phase; a zero element keeps angle zero.
  always_comb begin
    p_half = g_a >>> 1;
    sum_c  = dz_d[LC-1] ? '0 :
             zed_pkg::wrap_pi(zed_pkg::angx_t'(d_a) - zed_pkg::angx_t'(p_half));
    diff_c = cz_d[LC-1] ? '0 :
             zed_pkg::wrap_pi(zed_pkg::angx_t'(c_a) - zed_pkg::angx_t'(p_half));
  end

  zed_cordic #(.STAGES(CORDIC_STAGES)) u_beta (
    .clk(clk), .en(adv), .x_in(m00), .y_in(m01), .ang(beta_a), .mag()
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dz_d[0]   <= job.d_zero;
      cz_d[0]   <= job.c_zero;
      sum_d[0]  <= sum_c;
      diff_d[0] <= diff_c;
      g_d[0]    <= g_a;
      for (int k = 1; k < LC; k++) begin
        dz_d[k]   <= dz_d[k-1];
        cz_d[k]   <= cz_d[k-1];
        sum_d[k]  <= sum_d[k-1];
        diff_d[k] <= diff_d[k-1];
        g_d[k]    <= g_d[k-1];
      end

      // Combine
      alpha_r <= zed_pkg::rw_t'(sum_d[LC-1]) + zed_pkg::rw_t'(diff_d[LC-1]);
      gamma_r <= zed_pkg::rw_t'(sum_d[LC-1]) - zed_pkg::rw_t'(diff_d[LC-1]);
      phase_r <= zed_pkg::rw_t'(g_d[LC-1]);
      if (beta_a[zed_pkg::ZW-1]) begin
        beta_r <= '0;
      end else if (beta_a > zed_pkg::ang_t'(zed_pkg::HALF_PI_Q30)) begin
        beta_r <= zed_pkg::rw_t'(zed_pkg::HALF_PI_Q30) <<< 1;
      end else begin
        beta_r <= zed_pkg::rw_t'(beta_a) <<< 1;
      end

      // Round to nearest, ties upward
      alpha_q <= (alpha_r + zed_pkg::rw_t'(RND_HALF)) >>> SH;
      gamma_q <= (gamma_r + zed_pkg::rw_t'(RND_HALF)) >>> SH;
      beta_q  <= (beta_r  + zed_pkg::rw_t'(RND_HALF)) >>> SH;
      phase_q <= (phase_r + zed_pkg::rw_t'(RND_HALF)) >>> SH;

      // Output register
      alpha_angle  <= alpha_q[FRAC_BITS+3:0];
      beta_angle   <= beta_q[FRAC_BITS+1:0];
      gamma_angle  <= gamma_q[FRAC_BITS+3:0];
      global_phase <= phase_q[FRAC_BITS+2:0];
      alpha_needed <= abs_rw(alpha_q) > zed_pkg::RW'(tol);
      beta_needed  <= abs_rw(beta_q)  > zed_pkg::RW'(tol);
      gamma_needed <= abs_rw(gamma_q) > zed_pkg::RW'(tol);
      phase_needed <= abs_rw(phase_q) > zed_pkg::RW'(tol);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/zed_checker.sv */
// Port-level checks for zyz_euler_decompose, bound to the top level.
// Depends on zed_pkg and the top level's port list.
`default_nettype none
module zed_checker #(
  parameter int FRAC_BITS = zed_pkg::FRAC_BITS_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready,
  input wire logic [zed_pkg::TOL_W-1:0]        cfg_data,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic signed [FRAC_BITS+3:0]      alpha_angle,
  input wire logic        [FRAC_BITS+1:0]      beta_angle,
  input wire logic signed [FRAC_BITS+3:0]      gamma_angle,
  input wire logic signed [FRAC_BITS+2:0]      global_phase,
  input wire logic                             gamma_needed,
  input wire logic                             beta_needed,
  input wire logic                             alpha_needed,
  input wire logic                             phase_needed
);

  logic [zed_pkg::TOL_W-1:0] tol_seen;
  logic signed [31:0] a_ext, g_ext, p_ext;
  logic [31:0] a_abs, g_abs, p_abs, b_ext, t_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_seen <= zed_pkg::TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      tol_seen <= cfg_data;
    end
  end

  assign a_ext = 32'(alpha_angle);
  assign g_ext = 32'(gamma_angle);
  assign p_ext = 32'(global_phase);
  assign a_abs = a_ext[31] ? -a_ext : a_ext;
  assign g_abs = g_ext[31] ? -g_ext : g_ext;
  assign p_abs = p_ext[31] ? -p_ext : p_ext;
  assign b_ext = 32'(beta_angle);
  assign t_ext = 32'(tol_seen);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(alpha_angle) && $stable(beta_angle)
      && $stable(gamma_angle) && $stable(global_phase))
    else $error("stalled result changed or dropped");

  a_flags_bp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (beta_needed == (b_ext > t_ext)) && (phase_needed == (p_abs > t_ext)))
    else $error("beta or phase flag disagrees with its angle");

  a_flags_ag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (alpha_needed == (a_abs > t_ext)) && (gamma_needed == (g_abs > t_ext)))
    else $error("alpha or gamma flag disagrees with its angle");

endmodule

bind zyz_euler_decompose zed_checker #(.FRAC_BITS(FRAC_BITS)) u_zed_checker (
  .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
  .out_valid(out_valid), .out_stall(out_stall),
  .alpha_angle(alpha_angle), .beta_angle(beta_angle), .gamma_angle(gamma_angle),
  .global_phase(global_phase), .gamma_needed(gamma_needed), .beta_needed(beta_needed),
  .alpha_needed(alpha_needed), .phase_needed(phase_needed)
);
`default_nettype wire

/* bench/zyz_euler_decompose_test.sv */
// Self-checking bench for zyz_euler_decompose: random and directed 2x2 matrices,
// predicted ZYZ angles compared field by field. Depends on zed_pkg and the block.
`timescale 1ns / 1ps

// One set of output angles and flags, as expected or as seen on the ports.
typedef struct {
  logic signed [19:0] alpha;
  logic        [17:0] beta;
  logic signed [19:0] gamma;
  logic signed [18:0] phase;
  logic               gn, bn, an, pn;
} angles_t;

// Holds the expected angle sets in arrival order and checks each output transfer.
class euler_scoreboard;
  angles_t pending[$];
  int      errors;
  longint  tolerance;

  function new();
    errors = 0;
    tolerance = 1;
  endfunction

  static function longint asr(longint v, int s);
    return v >>> s;
  endfunction

  static function int top_bit(longint m);
    int p;
    p = 0;
    while (m > 1) begin
      m = m >> 1;
      p++;
    end
    return p;
  endfunction

  static function longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Vectoring CORDIC, Q.30 angle and gain-scaled magnitude.
  static function void vector_angle(longint x, longint y, output longint ang,
                                    output longint mag);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = zed_pkg::HALF_PI_Q30;
      end else begin
        x = -y; y = t; z = -zed_pkg::HALF_PI_Q30;
      end
    end
    for (int i = 0; i < 18; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(zed_pkg::atan_q30(i));
      end else begin
        x -= ys; y += xs; z -= longint'(zed_pkg::atan_q30(i));
      end
    end
    if (z > zed_pkg::PI_Q30) z = zed_pkg::PI_Q30;
    if (z < -zed_pkg::PI_Q30) z = -zed_pkg::PI_Q30;
    ang = z;
    mag = x;
  endfunction

  static function longint element_arg(longint re, longint im);
    longint a, m, mx;
    int s;
    mx = abs64(re) > abs64(im) ? abs64(re) : abs64(im);
    if (mx == 0) return 0;
    s = 40 - top_bit(mx);
    vector_angle(re <<< s, im <<< s, a, m);
    return a;
  endfunction

  static function longint wrap(longint a);
    if (a > zed_pkg::PI_Q30) a -= 2 * zed_pkg::PI_Q30;
    if (a <= -zed_pkg::PI_Q30) a += 2 * zed_pkg::PI_Q30;
    return a;
  endfunction

  static function longint round_out(longint v);
    return asr(v + (longint'(1) << 13), 14);
  endfunction

  // Note one accepted matrix and queue its expected angles.
  function void note_matrix(longint e[8]);
    longint dre, dim, g, p, sum, diff, beta, mx, m00, m01, t, oa, ob, oc, og;
    int s;
    angles_t r;
    dre = (e[0] * e[6] - e[1] * e[7]) - (e[2] * e[4] - e[3] * e[5]);
    dim = (e[0] * e[7] + e[1] * e[6]) - (e[2] * e[5] + e[3] * e[4]);
    g = element_arg(dre, dim);
    p = asr(g, 1);
    sum = 0; diff = 0; beta = 0;
    if (e[6] != 0 || e[7] != 0) sum = wrap(element_arg(e[6], e[7]) - p);
    if (e[4] != 0 || e[5] != 0) diff = wrap(element_arg(e[4], e[5]) - p);
    mx = abs64(e[0]);
    for (int i = 1; i < 4; i++) if (abs64(e[i]) > mx) mx = abs64(e[i]);
    if (mx != 0) begin
      s = 40 - top_bit(mx);
      vector_angle(e[0] <<< s, e[1] <<< s, t, m00);
      vector_angle(e[2] <<< s, e[3] <<< s, t, m01);
      vector_angle(m00, m01, beta, t);
      if (beta < 0) beta = 0;
      if (beta > zed_pkg::HALF_PI_Q30) beta = zed_pkg::HALF_PI_Q30;
      beta *= 2;
    end
    oa = round_out(sum + diff);
    ob = round_out(beta);
    oc = round_out(sum - diff);
    og = round_out(g);
    r.alpha = oa[19:0];
    r.beta  = ob[17:0];
    r.gamma = oc[19:0];
    r.phase = og[18:0];
    r.gn = abs64(oc) > tolerance;
    r.bn = abs64(ob) > tolerance;
    r.an = abs64(oa) > tolerance;
    r.pn = abs64(og) > tolerance;
    pending.push_back(r);
  endfunction

  function void check_angles(angles_t got);
    angles_t x;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result alpha=%0d", $time, got.alpha);
      errors++;
      return;
    end
    x = pending.pop_front();
    if (got.alpha !== x.alpha) begin
      $display("%0t: alpha exp %0d got %0d", $time, x.alpha, got.alpha); errors++;
    end
    if (got.beta !== x.beta) begin
      $display("%0t: beta exp %0d got %0d", $time, x.beta, got.beta); errors++;
    end
    if (got.gamma !== x.gamma) begin
      $display("%0t: gamma exp %0d got %0d", $time, x.gamma, got.gamma); errors++;
    end
    if (got.phase !== x.phase) begin
      $display("%0t: phase exp %0d got %0d", $time, x.phase, got.phase); errors++;
    end
    if ({got.gn, got.bn, got.an, got.pn} !== {x.gn, x.bn, x.an, x.pn}) begin
      $display("%0t: flags exp %b got %b", $time, {x.gn, x.bn, x.an, x.pn},
               {got.gn, got.bn, got.an, got.pn});
      errors++;
    end
  endfunction
endclass

module zyz_euler_decompose_test;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [17:0] u00_re = '0, u00_im = '0, u01_re = '0, u01_im = '0;
  logic signed [17:0] u10_re = '0, u10_im = '0, u11_re = '0, u11_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [19:0] alpha_angle, gamma_angle;
  logic        [17:0] beta_angle;
  logic signed [18:0] global_phase;
  logic gamma_needed, beta_needed, alpha_needed, phase_needed;

  euler_scoreboard board = new();
  bit stall_enable = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  zyz_euler_decompose u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .u00_re(u00_re), .u00_im(u00_im), .u01_re(u01_re), .u01_im(u01_im),
    .u10_re(u10_re), .u10_im(u10_im), .u11_re(u11_re), .u11_im(u11_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .alpha_angle(alpha_angle), .beta_angle(beta_angle), .gamma_angle(gamma_angle),
    .global_phase(global_phase), .gamma_needed(gamma_needed),
    .beta_needed(beta_needed), .alpha_needed(alpha_needed),
    .phase_needed(phase_needed)
  );

  // Check every output transfer as it happens at the clock edge.
  always @(posedge clk) begin
    angles_t got;
    if (!rst && out_valid && !out_stall) begin
      got.alpha = alpha_angle;
      got.beta  = beta_angle;
      got.gamma = gamma_angle;
      got.phase = global_phase;
      got.gn = gamma_needed;
      got.bn = beta_needed;
      got.an = alpha_needed;
      got.pn = phase_needed;
      board.check_angles(got);
    end
  end

  // Receiver back-pressure while stall_enable is set: each stall length drawn afresh.
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = stall_enable ? $urandom_range(0, 11) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Write the tolerance register; the scoreboard picks up the new value at once.
  task automatic write_tolerance(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.tolerance = longint'(value);
  endtask

  // Send one matrix; hold the payload until the transfer is taken.
  task automatic send_matrix(input logic signed [17:0] m[8], input int gap);
    longint e[8];
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {u00_re, u00_im, u01_re, u01_im} <= {m[0], m[1], m[2], m[3]};
    {u10_re, u10_im, u11_re, u11_im} <= {m[4], m[5], m[6], m[7]};
    do @(posedge clk); while (in_stall);
    foreach (e[i]) e[i] = m[i];
    board.note_matrix(e);
  endtask

  // Drain outstanding results, then let the pipeline settle before a register write.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [17:0] rand_part(int mode);
    case (mode)
      0: return 18'($urandom());                                // any pattern
      1: return 18'($urandom_range(0, 131072) - 65536);         // in range
      default: return 18'($urandom_range(0, 2) * 65536 - 65536); // -1, 0, +1
    endcase
  endfunction

  // Build an approximately unitary matrix from random angles.
  task automatic unitary_matrix(output logic signed [17:0] m[8]);
    real th, ph, la, de;
    th = $urandom_range(0, 10000) * 3.14159265 / 20000.0;
    ph = $urandom_range(0, 20000) * 3.14159265 / 10000.0;
    la = $urandom_range(0, 20000) * 3.14159265 / 10000.0;
    de = $urandom_range(0, 20000) * 3.14159265 / 10000.0;
    m[0] = 18'($rtoi(65536.0 * $cos(th) * $cos(de)));
    m[1] = 18'($rtoi(65536.0 * $cos(th) * $sin(de)));
    m[2] = 18'($rtoi(-65536.0 * $sin(th) * $cos(la + de)));
    m[3] = 18'($rtoi(-65536.0 * $sin(th) * $sin(la + de)));
    m[4] = 18'($rtoi(65536.0 * $sin(th) * $cos(ph + de)));
    m[5] = 18'($rtoi(65536.0 * $sin(th) * $sin(ph + de)));
    m[6] = 18'($rtoi(65536.0 * $cos(th) * $cos(ph + la + de)));
    m[7] = 18'($rtoi(65536.0 * $cos(th) * $sin(ph + la + de)));
  endtask

  initial begin
    logic signed [17:0] m[8];
    logic [15:0] tol_set[4];
    int pick;
    tol_set = '{16'd0, 16'd65535, 16'd200, 16'd1};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity, zero matrix, zero first row, zero determinant,
    // Pauli-like swaps and the extreme bit patterns.
    m = '{65536, 0, 0, 0, 0, 0, 65536, 0};           send_matrix(m, 0);
    m = '{0, 0, 0, 0, 0, 0, 0, 0};                   send_matrix(m, 0);
    m = '{0, 0, 0, 0, 65536, 0, 0, 65536};           send_matrix(m, 1);
    m = '{65536, 0, 65536, 0, 65536, 0, 65536, 0};   send_matrix(m, 0);
    m = '{0, 0, 65536, 0, 65536, 0, 0, 0};           send_matrix(m, 0);
    m = '{0, 0, 0, -65536, 0, 65536, 0, 0};          send_matrix(m, 2);
    m = '{-65536, 0, 0, 0, 0, 0, -65536, 0};         send_matrix(m, 0);
    m = '{0, 65536, 0, 0, 0, 0, 0, -65536};          send_matrix(m, 0);
    m = '{-131072, -131072, -131072, -131072, -131072, -131072, -131072, -131072};
    send_matrix(m, 0);
    m = '{131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071};
    send_matrix(m, 0);
    m = '{-131072, 131071, 1, -1, 131071, -131072, -1, 1};  send_matrix(m, 3);
    m = '{46341, 0, -46341, 0, 46341, 0, 46341, 0};  send_matrix(m, 0);
    m = '{1, 0, 0, 0, 0, 0, 0, 1};                   send_matrix(m, 0);
    m = '{0, 0, 1, 0, -1, 0, 0, 0};                  send_matrix(m, 0);
    m = '{-65536, 0, 0, 0, 0, 0, 65536, 0};          send_matrix(m, 0);

    // Random phases, each under its own tolerance setting.
    foreach (tol_set[k]) begin
      drain();
      write_tolerance(k == 3 ? 16'($urandom()) : tol_set[k]);
      stall_enable = (k != 2);
      for (int n = 0; n < 500; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          unitary_matrix(m);
        end else begin
          foreach (m[i]) m[i] = rand_part(pick - 6);
        end
        send_matrix(m, (k == 2 && n < 100) ? 0 : $urandom_range(0, 11));
      end
    end
    in_valid <= 1'b0;
    stall_enable = 1'b1;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
